### rtl/core/ordered_value_list_store_unit_macros.svh
// Assertion macros for the list store RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ORDERED_VALUE_LIST_STORE_UNIT_MACROS_SVH
`define ORDERED_VALUE_LIST_STORE_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define OVLS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define OVLS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define OVLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ovls_pkg.sv
// Package for the ordered value list store: sizes, operation and status
// codes, sequencer states and the structs passed between modules.
package ovls_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_SEARCH  = 3'd1,
        OP_REPLACE = 3'd2,
        OP_DELETE  = 3'd3,
        OP_DUMP    = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP,
        S_REPLY
    } t_state;

    // One result transaction
    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  value;
        logic                      last;
    } t_result;

    // Entry memory access request from the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

### rtl/core/ovls_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ovls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ovls_ctrl.sv
// Sequencer for the list store: walks the entry memory one entry per cycle for search,
// replace, delete (with gap closing) and dump (a dump only while its results are taken). Uses ovls_pkg.
`include "ordered_value_list_store_unit_macros.svh"

module ovls_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [2:0]                        i_func,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_key,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_new_value,
    output logic                              o_stall,
    output ovls_pkg::t_ram_req                o_ram_req,
    input  logic [ovls_pkg::DATA_W-1:0]       i_ram_rdata,
    output logic                              o_res_valid,
    output ovls_pkg::t_result                 o_result,
    input  logic                              i_res_ready
);

    import ovls_pkg::*;

    t_state                   r_state, n_state;
    logic [2:0]               r_func, n_func;
    logic [DATA_W-1:0]        r_key, n_key;
    logic [DATA_W-1:0]        r_new, n_new;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_idx, n_idx;
    t_status                  r_status, n_status;

    logic                     full;
    logic                     empty;
    logic                     hit;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         idx_inc2;
    logic                     next_in;
    logic                     shift_more;
    logic                     dump_last;

    t_ram_req                 ram_req;
    logic                     res_valid;
    t_result                  result;

    // Shared conditions
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign hit        = (i_ram_rdata == r_key);
    assign idx_inc    = r_idx + CNT_W'(1);
    assign idx_inc2   = r_idx + CNT_W'(2);
    assign next_in    = (idx_inc < r_count);
    assign shift_more = (idx_inc2 < r_count);
    assign dump_last  = (idx_inc == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        OP_APPEND: n_state = S_REPLY;
                        OP_SEARCH, OP_REPLACE, OP_DELETE:
                            n_state = empty ? S_REPLY : S_SCAN;
                        OP_DUMP: n_state = empty ? S_REPLY : S_DUMP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = (r_func == OP_DELETE && next_in) ? S_SHIFT : S_REPLY;
                end else begin
                    n_state = next_in ? S_SCAN : S_REPLY;
                end
            end
            S_SHIFT: n_state = shift_more ? S_SHIFT : S_REPLY;
            S_DUMP: begin
                if (i_res_ready && dump_last) begin
                    n_state = S_IDLE;
                end
            end
            S_REPLY: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory requests and result
    always_comb begin
        n_func   = r_func;
        n_key    = r_key;
        n_new    = r_new;
        n_count  = r_count;
        n_idx    = r_idx;
        n_status = r_status;
        ram_req  = '{we: 1'b0, waddr: r_idx[IDX_W-1:0], wdata: i_ram_rdata,
                     re: 1'b0, raddr: r_idx[IDX_W-1:0]};
        res_valid = 1'b0;
        result    = '{status: r_status, value: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func;
                    n_key  = i_key;
                    n_new  = i_new_value;
                    n_idx  = '0;
                    case (i_func)
                        OP_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = r_count[IDX_W-1:0];
                                ram_req.wdata = i_key;
                                n_count       = r_count + CNT_W'(1);
                                n_status      = ST_OK;
                            end
                        end
                        OP_SEARCH, OP_REPLACE, OP_DELETE, OP_DUMP: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // read data holds entry r_idx
            S_SCAN: begin
                if (hit) begin
                    n_status = ST_OK;
                    if (r_func == OP_REPLACE) begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = r_new;
                    end else if (r_func == OP_DELETE) begin
                        if (next_in) begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = idx_inc[IDX_W-1:0];
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end else if (next_in) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    n_idx         = idx_inc;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            // read data holds entry r_idx+1; move it down one place
            S_SHIFT: begin
                ram_req.we = 1'b1;
                if (shift_more) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_inc2[IDX_W-1:0];
                    n_idx         = idx_inc;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_OK;
                end
            end
            // one result per entry; read data holds while stalled
            S_DUMP: begin
                res_valid     = 1'b1;
                result.status = ST_OK;
                result.value  = i_ram_rdata;
                result.last   = dump_last;
                if (i_res_ready && !dump_last) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_inc[IDX_W-1:0];
                    n_idx         = idx_inc;
                end
            end
            S_REPLY: res_valid = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Transaction payload and walk registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_new    <= n_new;
        r_idx    <= n_idx;
        r_status <= n_status;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_ram_req   = ram_req;
    assign o_res_valid = res_valid;
    assign o_result    = result;

    `OVLS_ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `OVLS_ASSERT_IMPL(a_write_in_list, ram_req.we && r_state != S_IDLE, CNT_W'(ram_req.waddr) < r_count, "write past list end")
    `OVLS_ASSERT_IMPL(a_shift_delete, r_state == S_SHIFT, r_func == OP_DELETE, "gap closing outside delete")
    `OVLS_ASSERT_NEXT(a_result_hold, res_valid && !i_res_ready, res_valid && $stable(result.value) && $stable(result.last), "stalled result changed")

endmodule

### rtl/core/ordered_value_list_store_unit.sv
// Ordered value list store. Holds up to CAPACITY (16) signed 32-bit values in
// insertion order in a single entry RAM with a registered read.
// One transaction is worked on at a time; o_stall is high while it runs.
// Search, replace, delete and dump walk the list, reading one RAM entry per
// cycle through the single read port; a dump waits while its result is
// stalled. Results pass through an output register, so the next
// transaction can be taken while the last result still waits.
// Unused function codes produce no result. No clearing pass after reset.
// Depends on ovls_pkg, ovls_ram and ovls_ctrl.
module ordered_value_list_store_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [2:0]                         i_func,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_key,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_new_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic signed [ovls_pkg::DATA_W-1:0] o_value,
    output logic                               o_last
);

    import ovls_pkg::*;

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    t_result           result;
    logic              res_ready;

    logic              r_out_valid;
    t_result           r_out;

    // Entry storage
    ovls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // Operation sequencer
    ovls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_stall     (o_stall),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .o_result    (result),
        .i_res_ready (res_ready)
    );

    // Output register: loads when empty or being drained
    assign res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out.status;
    assign o_value  = r_out.value;
    assign o_last   = r_out.last;

endmodule

### tb/sv/ovls_list_checker.sv
// Scoreboard for ordered_value_list_store_unit: keeps its own copy of the list,
// predicts the result transactions of every accepted input transaction and
// checks the output channel against them in order. Depends on ovls_pkg.
module ovls_list_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [2:0]                         i_func,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_key,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_new_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [1:0]                         i_status,
    input  logic signed [ovls_pkg::DATA_W-1:0] i_value,
    input  logic                               i_last,
    output int                                 o_err_count,
    output int                                 o_pending
);
    import ovls_pkg::*;

    // Shadow of the stored values, front of the list first
    logic signed [DATA_W-1:0] stored[$];
    t_result                  expected_results[$];
    int                       err_count = 0;

    function automatic void queue_result(input t_status st,
                                         input logic signed [DATA_W-1:0] v,
                                         input logic lst);
        t_result r;
        r.status = st;
        r.value  = v;
        r.last   = lst;
        expected_results.push_back(r);
    endfunction

    // Apply one input transaction to the shadow list and queue its results
    function automatic void model_item(input logic [2:0] func,
                                       input logic signed [DATA_W-1:0] key,
                                       input logic signed [DATA_W-1:0] repl);
        int pos;
        pos = -1;
        for (int i = 0; i < stored.size(); i++) begin
            if (pos < 0 && stored[i] == key) pos = i;
        end
        case (func)
            OP_APPEND: begin
                if (stored.size() >= CAPACITY) begin
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    stored.push_back(key);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_SEARCH, OP_REPLACE, OP_DELETE: begin
                if (stored.size() == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else if (pos < 0) begin
                    queue_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    if (func == OP_REPLACE) stored[pos] = repl;
                    else if (func == OP_DELETE) stored.delete(pos);
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DUMP: begin
                if (stored.size() == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    foreach (stored[i]) queue_result(ST_OK, stored[i], i == stored.size() - 1);
                end
            end
            default: ; // unused codes leave everything as it is
        endcase
    endfunction

    // Results are checked before the input of the same edge is predicted:
    // a result can never belong to a transaction accepted at the same edge.
    always @(posedge i_clk) begin : watch
        t_result exp_res;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, got status %0d value %0d last %0d",
                             $time, i_status, i_value, i_last);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_status !== exp_res.status) begin
                        err_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, exp_res.status, i_status);
                    end
                    if (i_value !== exp_res.value) begin
                        err_count++;
                        $display("%0t: value mismatch, expected %0d, got %0d",
                                 $time, exp_res.value, i_value);
                    end
                    if (i_last !== exp_res.last) begin
                        err_count++;
                        $display("%0t: last mismatch, expected %0d, got %0d",
                                 $time, exp_res.last, i_last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) model_item(i_func, i_key, i_new_value);
        end
        o_err_count <= err_count;
        o_pending   <= expected_results.size();
    end

endmodule

### tb/sv/tb_top.sv
// Top of the list store testbench: clock, reset, stimulus and the verdict.
// Depends on ovls_pkg, ordered_value_list_store_unit and ovls_list_checker.
module tb_top;
    import ovls_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 330;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_stall;
    logic [2:0]               i_func      = '0;
    logic signed [DATA_W-1:0] i_key       = '0;
    logic signed [DATA_W-1:0] i_new_value = '0;
    logic                     o_valid;
    logic                     i_stall     = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_value;
    logic                     o_last;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int results_taken = 0;
    int send_left     = 0;
    bit send_calm     = 1'b0;

    logic signed [DATA_W-1:0] key_pool[8];

    always #5 i_clk = ~i_clk;

    ordered_value_list_store_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_last      (o_last)
    );

    ovls_list_checker u_list_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_new_value (i_new_value),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (o_status),
        .i_value     (o_value),
        .i_last      (o_last),
        .o_err_count (fail_count),
        .o_pending   (pending)
    );

    // Offer one input transaction after a random gap; returns at the edge
    // where it is taken, with valid still high.
    task automatic offer_item(input logic [2:0] func,
                              input logic signed [DATA_W-1:0] key,
                              input logic signed [DATA_W-1:0] repl);
        int gap;
        if (send_left == 0) begin
            send_left = $urandom_range(10, 40);
            send_calm = ($urandom_range(0, 3) == 0);
        end
        send_left--;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= func;
        i_key       <= key;
        i_new_value <= repl;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Mostly values from the current pool so lookups hit stored entries
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Receiver: random stall per result, two long hold-offs to back up the block
    initial begin : drain
        int hold;
        int recv_left;
        bit recv_calm;
        recv_left = 0;
        recv_calm = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (recv_left == 0) begin
                recv_left = $urandom_range(10, 40);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            recv_left--;
            if (results_taken == 40 || results_taken == 250) hold = LONG_HOLD;
            else hold = recv_calm ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            results_taken++;
        end
    end

    // Run limit
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** ordered_value_list_store_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int         made;
        int         phase_left;
        int         roll;
        bit         filling;
        logic [2:0] func;
        made       = 0;
        phase_left = 0;
        filling    = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list on every operation, then the single-entry delete
        offer_item(OP_DUMP, '0, '0);
        offer_item(OP_SEARCH, 32'sd7, '0);
        offer_item(OP_REPLACE, 32'sd7, 32'sd9);
        offer_item(OP_DELETE, 32'sd7, '0);
        offer_item(OP_APPEND, 32'sd7, '0);
        offer_item(OP_DELETE, 32'sd7, '0);
        offer_item(OP_SEARCH, 32'sd7, '0);

        // Extremes and a duplicate; first match wins
        offer_item(OP_APPEND, MIN_VAL, '0);
        offer_item(OP_APPEND, MAX_VAL, '0);
        offer_item(OP_APPEND, '0, '0);
        offer_item(OP_APPEND, -32'sd1, '0);
        offer_item(OP_APPEND, MIN_VAL, '0);
        offer_item(OP_SEARCH, MAX_VAL, '0);
        offer_item(OP_SEARCH, 32'sd99, '0);
        offer_item(OP_REPLACE, MIN_VAL, 32'sh5A5A_A5A5);
        offer_item(OP_DELETE, -32'sd1, '0);

        // Fill up, append past capacity, dump the full list
        for (int n = 0; n < CAPACITY - 4; n++) offer_item(OP_APPEND, $urandom, '0);
        offer_item(OP_APPEND, MAX_VAL, '0);
        offer_item(OP_DUMP, '0, MIN_VAL);

        // Unused codes are ignored
        for (int c = 5; c < 8; c++) offer_item(3'(c), $urandom, $urandom);

        // Random: alternating fill and drain phases over a small value pool
        while (made < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(20, 60);
                foreach (key_pool[i]) begin
                    case ($urandom_range(0, 7))
                        0:       key_pool[i] = MIN_VAL;
                        1:       key_pool[i] = MAX_VAL;
                        2:       key_pool[i] = '0;
                        3:       key_pool[i] = -32'sd1;
                        default: key_pool[i] = $urandom;
                    endcase
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)                         func = 3'($urandom_range(5, 7));
            else if (roll < (filling ? 60 : 18))  func = OP_APPEND;
            else if (roll < (filling ? 70 : 28))  func = OP_SEARCH;
            else if (roll < (filling ? 80 : 38))  func = OP_REPLACE;
            else if (roll < (filling ? 90 : 88))  func = OP_DELETE;
            else                                  func = OP_DUMP;
            offer_item(func, pick_value(), pick_value());
            if (func <= OP_DUMP) begin
                made++;
                phase_left--;
            end
        end
        i_valid <= 1'b0;

        // One edge for the last prediction to show, then wait for all results
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** ordered_value_list_store_unit: PASSED **");
        end else begin
            $display("** ordered_value_list_store_unit: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ovls_pkg.sv
rtl/core/ovls_ram.sv
rtl/core/ovls_ctrl.sv
rtl/core/ordered_value_list_store_unit.sv
tb/sv/ovls_list_checker.sv
tb/sv/tb_top.sv
